// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the cache RTL.
// Depends on clk and rst_n being visible in the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SALRU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`define SALRU_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/salru_pkg.sv -----
// Package for the set-associative LRU write-back cache: sizes, line layout,
// configuration codes and geometry helpers. No dependencies.
package salru_pkg;

  localparam int LINES     = 1024;
  localparam int MAX_WAYS  = 8;
  localparam int ADDR_BITS = 32;

  localparam int LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int BLK_W   = 32;
  localparam int WAY_LIM0 = (MAX_WAYS < LINES) ? MAX_WAYS : LINES;
  localparam int WAY_LIM  = (WAY_LIM0 < 15) ? WAY_LIM0 : 15;
  localparam int WAY_W    = (WAY_LIM > 1) ? $clog2(WAY_LIM) : 1;

  localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd0;
  localparam logic [1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [3:0] RST_BLOCK_BITS  = 4'd6;
  localparam logic [3:0] RST_SET_BITS    = 4'd7;
  localparam logic [3:0] RST_WAYS_IN_USE = 4'd8;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [31:0]      stamp;
    logic [BLK_W-1:0] blk;
  } line_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [3:0] eff_ways(input logic [3:0] w);
    logic [3:0] r;
    r = (w == 4'd0) ? 4'd1 : w;
    if (int'(r) > WAY_LIM) r = 4'(WAY_LIM);
    return r;
  endfunction

  function automatic logic [3:0] eff_set_bits(input logic [3:0] sb, input logic [3:0] ways);
    logic [3:0] r;
    r = 4'd0;
    for (int s = 0; s < 16; s++) begin
      if ((4'(s) <= sb) && ((int'(ways) << s) <= LINES)) r = 4'(s);
    end
    return r;
  endfunction

endpackage

// ----- rtl/salru_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/set_assoc_lru_writeback_cache.sv -----
// Top level of the set-associative LRU write-back cache tag model.
// Depends on salru_pkg, salru_ram and assert_macros.svh.
//
// Usage: the in_ channel carries one access word (req_type, address); the
// out_ channel returns one result word per access with the hit flag, the
// fill and write-back requests for the next level and four saturating
// counters. The cfg_ channel writes block_bits (index 0), set_bits (index 1)
// and ways_in_use (index 2); it is always ready. The user must see that it
// is written only while idle; the block itself does not enforce this. The
// sequencer reads each effective way from the line memory, one way per
// cycle, and runs it through one shared tag and timestamp comparator, then
// writes the line back. After reset the line memory is cleared one entry
// per cycle; in_ready stays low meanwhile. A stalled receiver holds the
// result in the output register; the next access may still be accepted and
// scanned, and it waits in its final cycle until the output register frees.
`include "assert_macros.svh"

module set_assoc_lru_writeback_cache
  import salru_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_fill_valid,
  output logic [31:0] out_fill_addr,
  output logic        out_writeback_valid,
  output logic [31:0] out_writeback_addr,
  output logic [31:0] out_access_count,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_writeback_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_UPD} state_t;

  state_t             state_r;
  logic [LINE_W-1:0]  clr_idx_r;
  logic [3:0]         block_bits_r;
  logic [3:0]         set_bits_r;
  logic [3:0]         ways_in_use_r;
  logic               req_wr_r;
  logic [31:0]        addr_r;
  logic [BLK_W-1:0]   blk_r;
  logic [LINE_W-1:0]  base_r;
  logic [31:0]        tick_r;
  logic [31:0]        acc_cnt_r;
  logic [31:0]        hit_cnt_r;
  logic [31:0]        miss_cnt_r;
  logic [31:0]        wb_cnt_r;
  logic [WAY_W-1:0]   way_r;
  logic               chk_r;
  logic [WAY_W-1:0]   chk_way_r;
  logic               hit_r;
  logic [WAY_W-1:0]   hit_way_r;
  logic               hit_dirty_r;
  logic               inv_r;
  logic [WAY_W-1:0]   inv_way_r;
  logic [WAY_W-1:0]   lru_way_r;
  logic [31:0]        lru_stamp_r;
  logic               lru_dirty_r;
  logic [BLK_W-1:0]   lru_blk_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic               out_fill_valid_r;
  logic [31:0]        out_fill_addr_r;
  logic               out_wb_valid_r;
  logic [31:0]        out_wb_addr_r;
  logic [31:0]        out_acc_cnt_r;
  logic [31:0]        out_hit_cnt_r;
  logic [31:0]        out_miss_cnt_r;
  logic [31:0]        out_wb_cnt_r;

  logic [3:0]         ways_eff;
  logic [3:0]         sb_eff;
  logic [WAY_W-1:0]   last_way;
  logic [31:0]        in_addr_m;
  logic [BLK_W-1:0]   in_blk;
  logic [LINE_W:0]    set_span;
  logic [LINE_W-1:0]  set_mask;
  logic [LINE_W-1:0]  in_base;
  logic               in_fire;
  logic               upd_fire;
  line_t              rd_line;
  logic               match;
  logic               older;
  logic [WAY_W-1:0]   vic_way;
  logic [WAY_W-1:0]   wr_way;
  logic               wb;
  logic               mem_we;
  logic [LINE_W-1:0]  mem_waddr;
  line_t              mem_wdata;
  logic               mem_re;
  logic [LINE_W-1:0]  mem_raddr;
  logic [31:0]        hit_cnt_nxt;
  logic [31:0]        miss_cnt_nxt;
  logic [31:0]        wb_cnt_nxt;
  logic [31:0]        wb_addr_nxt;

  assign ways_eff  = eff_ways(ways_in_use_r);
  assign sb_eff    = eff_set_bits(set_bits_r, ways_eff);
  assign last_way  = WAY_W'(ways_eff - 4'd1);
  assign in_addr_m = in_address & ADDR_MASK;
  assign in_blk    = BLK_W'(in_addr_m >> block_bits_r);
  assign set_span  = (LINE_W + 1)'(1) << sb_eff;
  assign set_mask  = LINE_W'(set_span - (LINE_W + 1)'(1));
  assign in_base   = LINE_W'((in_blk[LINE_W-1:0] & set_mask) * ways_eff);

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign upd_fire  = (state_r == S_UPD) && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  assign match   = rd_line.valid && (rd_line.blk == blk_r);
  assign older   = rd_line.stamp < lru_stamp_r;
  assign vic_way = inv_r ? inv_way_r : lru_way_r;
  assign wr_way  = hit_r ? hit_way_r : vic_way;
  assign wb      = !hit_r && !inv_r && lru_dirty_r;

  assign hit_cnt_nxt  = hit_r ? sat_inc(hit_cnt_r) : hit_cnt_r;
  assign miss_cnt_nxt = hit_r ? miss_cnt_r : sat_inc(miss_cnt_r);
  assign wb_cnt_nxt   = wb ? sat_inc(wb_cnt_r) : wb_cnt_r;
  assign wb_addr_nxt  = wb ? (32'(lru_blk_r << block_bits_r) & ADDR_MASK) : 32'd0;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx_r;
    mem_wdata = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (upd_fire) begin
      mem_we          = 1'b1;
      mem_waddr       = LINE_W'(base_r + LINE_W'(wr_way));
      mem_wdata.valid = 1'b1;
      mem_wdata.dirty = hit_r ? (hit_dirty_r | req_wr_r) : req_wr_r;
      mem_wdata.stamp = tick_r;
      mem_wdata.blk   = blk_r;
    end
  end

  assign mem_re    = (state_r == S_SCAN);
  assign mem_raddr = LINE_W'(base_r + LINE_W'(way_r));

  salru_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (LINES)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_line)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      block_bits_r  <= RST_BLOCK_BITS;
      set_bits_r    <= RST_SET_BITS;
      ways_in_use_r <= RST_WAYS_IN_USE;
      tick_r        <= '0;
      acc_cnt_r     <= '0;
      hit_cnt_r     <= '0;
      miss_cnt_r    <= '0;
      wb_cnt_r      <= '0;
      chk_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_BLOCK_BITS:  block_bits_r  <= cfg_data;
          CFG_SET_BITS:    set_bits_r    <= cfg_data;
          CFG_WAYS_IN_USE: ways_in_use_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready && !upd_fire) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= LINE_W'(clr_idx_r + LINE_W'(1));
          if (clr_idx_r == LINE_W'(LINES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            req_wr_r  <= in_req_type;
            addr_r    <= in_addr_m;
            blk_r     <= in_blk;
            base_r    <= in_base;
            tick_r    <= tick_r + 32'd1;
            acc_cnt_r <= sat_inc(acc_cnt_r);
            way_r     <= '0;
            chk_r     <= 1'b0;
            hit_r     <= 1'b0;
            inv_r     <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (way_r != last_way) begin
            way_r <= WAY_W'(way_r + WAY_W'(1));
          end
          chk_r     <= 1'b1;
          chk_way_r <= way_r;
          if (chk_r) begin
            if (!hit_r && match) begin
              hit_r       <= 1'b1;
              hit_way_r   <= chk_way_r;
              hit_dirty_r <= rd_line.dirty;
            end
            if (!inv_r && !rd_line.valid) begin
              inv_r     <= 1'b1;
              inv_way_r <= chk_way_r;
            end
            if ((chk_way_r == '0) || older) begin
              lru_way_r   <= chk_way_r;
              lru_stamp_r <= rd_line.stamp;
              lru_dirty_r <= rd_line.dirty;
              lru_blk_r   <= rd_line.blk;
            end
            if (chk_way_r == last_way) begin
              state_r <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (upd_fire) begin
            hit_cnt_r        <= hit_cnt_nxt;
            miss_cnt_r       <= miss_cnt_nxt;
            wb_cnt_r         <= wb_cnt_nxt;
            out_valid_r      <= 1'b1;
            out_hit_r        <= hit_r;
            out_fill_valid_r <= !hit_r;
            out_fill_addr_r  <= hit_r ? 32'd0 : addr_r;
            out_wb_valid_r   <= wb;
            out_wb_addr_r    <= wb_addr_nxt;
            out_acc_cnt_r    <= acc_cnt_r;
            out_hit_cnt_r    <= hit_cnt_nxt;
            out_miss_cnt_r   <= miss_cnt_nxt;
            out_wb_cnt_r     <= wb_cnt_nxt;
            chk_r            <= 1'b0;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_fill_valid      = out_fill_valid_r;
  assign out_fill_addr       = out_fill_addr_r;
  assign out_writeback_valid = out_wb_valid_r;
  assign out_writeback_addr  = out_wb_addr_r;
  assign out_access_count    = out_acc_cnt_r;
  assign out_hit_count       = out_hit_cnt_r;
  assign out_miss_count      = out_miss_cnt_r;
  assign out_writeback_count = out_wb_cnt_r;

  `SALRU_ASSERT_IMPLY(a_hit_xor_fill, out_valid_r, out_hit_r ^ out_fill_valid_r, "Bad hit flag.")
  `SALRU_ASSERT_IMPLY(a_wb_on_miss, out_valid_r && out_wb_valid_r, out_fill_valid_r, "Stray write-back.")
  `SALRU_ASSERT_IMPLY(a_hits_bounded, out_valid_r, out_hit_cnt_r <= out_acc_cnt_r, "Hit count too high.")
  `SALRU_ASSERT_IMPLY(a_miss_bounded, out_valid_r, out_miss_cnt_r <= out_acc_cnt_r, "Miss count high.")
  `SALRU_ASSERT_IMPLY(a_way_range, mem_re && chk_r, chk_way_r <= last_way, "Way out of range.")
  `SALRU_ASSERT_ALWAYS(a_no_scan_write, !(mem_re && mem_we), "Line memory written during a scan.")

endmodule
